/* design/svc_pkg.sv */
package svc_pkg;

  localparam int VALUE_W    = 64;
  localparam int VALUE_BITS = 64;
  localparam int GROUP_BITS = 7;
  localparam int MAX_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int CNT_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SHIFT_W    = $clog2(MAX_GROUPS * GROUP_BITS);

  localparam logic       MODE_ENCODE = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;
  localparam logic [7:0] MORE_FLAG   = 8'h80;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENC,
    S_DEC
  } state_e;

  typedef struct packed {
    logic                       mode;
    logic signed [VALUE_W-1:0]  value;
    logic [7:0]                 in_byte;
    logic                       end_of_stream;
  } svc_in_t;

  typedef struct packed {
    logic [7:0]                 out_byte;
    logic signed [VALUE_W-1:0]  out_value;
    status_e                    status;
    logic                       last;
  } svc_out_t;

endpackage

/* design/signed_varint_codec.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_ready_o  | in_data_i  (svc_in_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (svc_out_t)
//
// encode: the request is taken, then the shared code-word shift register
//   sends one group per cycle while the output is not stalled; a value
//   takes n groups (1 to MAX_GROUPS).
// decode: one byte per cycle while no result waits; a closing byte (last
//   group, overflow or end of stream) shows the single result until taken.
// reset clears state, accumulator and group count; output stalls hold the
//   shift register and the block takes no request until the last group leaves.
module signed_varint_codec (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  svc_pkg::svc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output svc_pkg::svc_out_t out_data_o
);
  import svc_pkg::*;

  state_e                 state_q, state_d;
  logic [VALUE_BITS-1:0]  code_q, code_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]       gc_q, gc_d;
  status_e                status_q, status_d;
  logic                   mode_q, mode_d;

  logic                   in_fire, out_fire;
  logic                   more_out;
  logic [VALUE_BITS-1:0]  vlow, magv, code_enc;
  logic                   neg_in;
  logic [SHIFT_W-1:0]     shift;
  logic [VALUE_BITS-1:0]  acc_new;
  logic [CNT_W:0]         gc_inc;
  logic                   more_in, ovf;
  logic [VALUE_BITS-1:0]  dec_mag;
  logic signed [VALUE_BITS-1:0] dec_val;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign more_out = |code_q[VALUE_BITS-1:GROUP_BITS];

  // sign-magnitude code word, magnitude loses its top bit
  assign vlow     = in_data_i.value[VALUE_BITS-1:0];
  assign neg_in   = vlow[VALUE_BITS-1];
  assign magv     = neg_in ? (VALUE_BITS'(0) - vlow) : vlow;
  assign code_enc = {magv[VALUE_BITS-2:0], neg_in};

  assign shift   = SHIFT_W'(gc_q * GROUP_BITS);
  assign acc_new = acc_q | (VALUE_BITS'(in_data_i.in_byte[6:0]) << shift);
  assign more_in = in_data_i.in_byte[7];
  assign gc_inc  = {1'b0, gc_q} + 1'b1;
  assign ovf     = more_in && (gc_inc >= (CNT_W+1)'(MAX_GROUPS));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.mode == MODE_ENCODE) begin
            state_d = S_ENC;
          end else if (!more_in || ovf || in_data_i.end_of_stream) begin
            state_d = S_DEC;
          end
        end
      end
      S_ENC: begin
        if (out_fire && !more_out) state_d = S_IDLE;
      end
      S_DEC: begin
        if (out_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    code_d   = code_q;
    acc_d    = acc_q;
    gc_d     = gc_q;
    status_d = status_q;
    mode_d   = mode_q;
    if (in_fire) begin
      mode_d = in_data_i.mode;
      if (in_data_i.mode == MODE_ENCODE) begin
        code_d   = code_enc;
        status_d = ST_OK;
      end else if (!more_in) begin
        code_d   = acc_new;
        status_d = ST_OK;
        acc_d    = '0;
        gc_d     = '0;
      end else if (ovf) begin
        code_d   = '0;
        status_d = ST_OVERFLOW;
        acc_d    = '0;
        gc_d     = '0;
      end else if (in_data_i.end_of_stream) begin
        code_d   = acc_new;
        status_d = ST_TRUNC;
        acc_d    = '0;
        gc_d     = '0;
      end else begin
        acc_d = acc_new;
        gc_d  = gc_inc[CNT_W-1:0];
      end
    end else if (state_q == S_ENC && out_fire) begin
      code_d = code_q >> GROUP_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      acc_q    <= '0;
      gc_q     <= '0;
      mode_q   <= MODE_ENCODE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      gc_q     <= gc_d;
      mode_q   <= mode_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  // code word read back: low bit is the sign
  assign dec_mag = code_q >> 1;
  assign dec_val = code_q[0] ? (VALUE_BITS'(0) - dec_mag) : dec_mag;

  // outputs
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q != S_IDLE);
    out_data_o  = '0;
    unique case (state_q)
      S_ENC: begin
        out_data_o.out_byte = {more_out, code_q[6:0]};
        out_data_o.last     = !more_out;
        out_data_o.status   = ST_OK;
      end
      S_DEC: begin
        out_data_o.out_value = VALUE_W'(dec_val);
        out_data_o.status    = status_q;
        out_data_o.last      = 1'b1;
      end
      default: begin
        out_data_o = '0;
      end
    endcase
  end

  a_enc_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ENC && out_fire && more_out) |=> (state_q == S_ENC && out_valid_o))
    else $error("encoder stopped before the final group");

  a_status_decode_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |->
      (mode_q == MODE_DECODE && state_q == S_DEC))
    else $error("error status outside decode result");

  a_gc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, gc_q} < (CNT_W+1)'(MAX_GROUPS)))
    else $error("group count out of range");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_OVERFLOW) |-> (out_data_o.out_value == '0))
    else $error("overflow result carries a value");

endmodule
